// File: rtl/core/krt_pkg.sv
`default_nettype none

package krt_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_CHARS_DEF = 8;
	localparam logic [7:0] OLD_AGE_RESET = 8'd18;

	localparam int KEY_W    = 64;
	localparam int AGE_W    = 8;
	localparam int POINTS_W = 32;
	localparam int INDEX_W  = 6;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [2:0] {
		OP_ADD        = 3'd0,
		OP_DELETE     = 3'd1,
		OP_SET_AGE    = 3'd2,
		OP_SET_POINTS = 3'd3,
		OP_READ       = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]                 opcode;
		logic [KEY_W-1:0]           key;
		logic [AGE_W-1:0]           age;
		logic signed [POINTS_W-1:0] points;
		logic [INDEX_W-1:0]         index;
	} in_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic [POS_W-1:0]           position;
		logic [KEY_W-1:0]           found_key;
		logic [AGE_W-1:0]           found_age;
		logic signed [POINTS_W-1:0] found_points;
		logic                       is_old;
		logic [COUNT_W-1:0]         entry_count;
	} out_t;

	typedef struct packed {
		logic [KEY_W-1:0]           key;
		logic [AGE_W-1:0]           age;
		logic signed [POINTS_W-1:0] points;
	} rec_t;

endpackage

`default_nettype wire

// File: rtl/core/keyed_record_table_core.sv
`default_nettype none
// Keyed record table: up to CAPACITY records (key, age, points) in insertion order.
// Input channel in_valid/in_ready/in_data carries one command beat; output channel
// out_valid/out_ready/out_data returns exactly one result beat per command.
// cfg_we/cfg_wdata writes the old-age threshold (reset 18).
// Commands run one at a time on a record memory with one write and one registered read port:
//   add, unused opcode or any early failure: settled in the dispatch step
//   read by index: dispatch issues the read, a wait step captures the record
//   update age/points: search to the first match and rewrite it; on a miss, search all
//   delete: search up to the hit, then shift the rest down
// in_ready is low for the whole command and goes high again as the result is issued.
// The result sits in an output register; the next command is accepted while it
// waits. A finished command holds in its last step until the output register is
// free, so a stalled receiver stalls the table after at most one queued command.
// Reset empties the table (count 0) and restores the threshold; the memory itself
// is not cleared, since only entries below the count are ever read.
module keyed_record_table_core #(
	parameter int CAPACITY  = krt_pkg::CAPACITY_DEF,
	parameter int KEY_CHARS = krt_pkg::KEY_CHARS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire krt_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output krt_pkg::out_t      out_data,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata
);

	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int CMPW     = (CW > krt_pkg::INDEX_W) ? CW : krt_pkg::INDEX_W;
	localparam int KEY_BITS = 8 * KEY_CHARS;
	localparam logic [krt_pkg::KEY_W-1:0] KeyMask =
		{krt_pkg::KEY_W{1'b1}} >> (krt_pkg::KEY_W - KEY_BITS);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DISP   = 6'b000010,
		S_SEARCH = 6'b000100,
		S_SHIFT  = 6'b001000,
		S_RDWAIT = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [2:0]                          op_q;
	logic [krt_pkg::KEY_W-1:0]           key_q;
	logic [krt_pkg::AGE_W-1:0]           age_q;
	logic signed [krt_pkg::POINTS_W-1:0] pts_q;
	logic [krt_pkg::INDEX_W-1:0]         idx_q;

	logic [AW-1:0] ptr_q, ptr_d, ptr_nxt;
	logic [CW-1:0] count_q, count_d;
	logic          ptr_last;
	logic [7:0]    thr_q;
	krt_pkg::out_t res_q, res_d, res_fin;

	krt_pkg::rec_t mem [CAPACITY];
	krt_pkg::rec_t rd_q, wd;
	logic          we;
	logic [AW-1:0] wa, ra;
	logic          out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;
	assign ptr_nxt  = ptr_q + AW'(1);
	assign ptr_last = ((CW'(ptr_q) + CW'(1)) == count_q);

	always_comb begin
		state_d = state_q;
		ptr_d   = ptr_q;
		count_d = count_q;
		res_d   = res_q;
		we      = 1'b0;
		wa      = ptr_q;
		wd      = rd_q;
		ra      = ptr_nxt;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				res_d   = '0;
				state_d = S_FIN;
				unique case (op_q)
					krt_pkg::OP_ADD: begin
						if (count_q >= CW'(CAPACITY)) begin
							res_d.status = krt_pkg::ST_FULL;
						end else begin
							we = 1'b1;
							wa = count_q[AW-1:0];
							wd = '{key: key_q, age: age_q, points: pts_q};
							res_d.position = krt_pkg::POS_W'(count_q);
							count_d = count_q + CW'(1);
						end
					end
					krt_pkg::OP_DELETE, krt_pkg::OP_SET_AGE, krt_pkg::OP_SET_POINTS: begin
						if (count_q == '0) begin
							res_d.status = krt_pkg::ST_MISSING;
						end else begin
							ra      = '0;
							ptr_d   = '0;
							state_d = S_SEARCH;
						end
					end
					krt_pkg::OP_READ: begin
						if (CMPW'(idx_q) >= CMPW'(count_q)) begin
							res_d.status = krt_pkg::ST_RANGE;
						end else begin
							ra             = AW'(idx_q);
							res_d.position = krt_pkg::POS_W'(idx_q);
							state_d        = S_RDWAIT;
						end
					end
					default: begin
					end
				endcase
			end
			S_SEARCH: begin
				if (rd_q.key == key_q) begin
					res_d.position = krt_pkg::POS_W'(ptr_q);
					if (op_q == krt_pkg::OP_SET_AGE) begin
						we      = 1'b1;
						wd.age  = age_q;
						state_d = S_FIN;
					end else if (op_q == krt_pkg::OP_SET_POINTS) begin
						we        = 1'b1;
						wd.points = pts_q;
						state_d   = S_FIN;
					end else if (ptr_last) begin
						count_d = count_q - CW'(1);
						state_d = S_FIN;
					end else begin
						ptr_d   = ptr_nxt;
						state_d = S_SHIFT;
					end
				end else if (ptr_last) begin
					res_d.status = krt_pkg::ST_MISSING;
					state_d      = S_FIN;
				end else begin
					ptr_d = ptr_nxt;
				end
			end
			S_SHIFT: begin
				// move the entry just read down one place
				we = 1'b1;
				wa = ptr_q - AW'(1);
				if (ptr_last) begin
					count_d = count_q - CW'(1);
					state_d = S_FIN;
				end else begin
					ptr_d = ptr_nxt;
				end
			end
			S_RDWAIT: begin
				res_d.found_key    = rd_q.key;
				res_d.found_age    = rd_q.age;
				res_d.found_points = rd_q.points;
				res_d.is_old       = (rd_q.age >= thr_q);
				state_d            = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		res_fin             = res_q;
		res_fin.entry_count = krt_pkg::COUNT_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			thr_q     <= krt_pkg::OLD_AGE_RESET;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (state_q == S_FIN && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		res_q <= res_d;
		if (in_valid && in_ready) begin
			op_q  <= in_data.opcode;
			key_q <= in_data.key & KeyMask;
			age_q <= in_data.age;
			pts_q <= in_data.points;
			idx_q <= in_data.index;
		end
		if (state_q == S_FIN && out_free) begin
			out_data <= res_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[ra];
	end

endmodule

`default_nettype wire

// File: rtl/core/krt_checker.sv
`default_nettype none

module krt_checker #(
	parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire krt_pkg::out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted on back-to-back cycles");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == krt_pkg::ST_FULL
		|-> out_data.entry_count == krt_pkg::COUNT_W'(CAPACITY))
		else $error("table full reported below capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != krt_pkg::ST_OK
		|-> out_data.position == '0 && out_data.found_key == '0 && !out_data.is_old)
		else $error("failed command returned record fields");

endmodule

bind keyed_record_table_core krt_checker #(.CAPACITY(CAPACITY)) u_krt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// File: tb/keyed_record_table_checker.sv
`timescale 1ns / 1ps

module keyed_record_table_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  krt_pkg::in_t   in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  krt_pkg::out_t  out_data,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata,
	output int             errors,
	output int             pending
);
	import krt_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam logic [KEY_W-1:0] KEY_MASK = (KEY_CHARS_DEF >= 8) ? {KEY_W{1'b1}} :
		((64'd1 << (8 * KEY_CHARS_DEF)) - 64'd1);

	logic [KEY_W-1:0]           key_mem [CAP];
	logic [AGE_W-1:0]           age_mem [CAP];
	logic signed [POINTS_W-1:0] pts_mem [CAP];
	int                         held;
	logic [7:0]                 old_age;
	out_t                       result_q [$];
	int                         shown;
	bit                         beat_bad;

	task automatic predict_result(input in_t cmd, output out_t res);
		logic [KEY_W-1:0] k;
		int hit;
		res = '0;
		k = cmd.key & KEY_MASK;
		case (cmd.opcode)
			OP_ADD: begin
				if (held >= CAP) begin
					res.status = ST_FULL;
				end else begin
					key_mem[held] = k;
					age_mem[held] = cmd.age;
					pts_mem[held] = cmd.points;
					res.position = held[POS_W-1:0];
					held++;
				end
			end
			OP_DELETE, OP_SET_AGE, OP_SET_POINTS: begin
				hit = held;
				for (int i = held - 1; i >= 0; i--)
					if (key_mem[i] == k) hit = i;
				if (hit == held) begin
					res.status = ST_MISSING;
				end else begin
					res.position = hit[POS_W-1:0];
					if (cmd.opcode == OP_DELETE) begin
						for (int i = hit; i < held - 1; i++) begin
							key_mem[i] = key_mem[i + 1];
							age_mem[i] = age_mem[i + 1];
							pts_mem[i] = pts_mem[i + 1];
						end
						held--;
					end else if (cmd.opcode == OP_SET_AGE) begin
						age_mem[hit] = cmd.age;
					end else begin
						pts_mem[hit] = cmd.points;
					end
				end
			end
			OP_READ: begin
				if (int'(cmd.index) >= held) begin
					res.status = ST_RANGE;
				end else begin
					res.position = cmd.index;
					res.found_key = key_mem[cmd.index];
					res.found_age = age_mem[cmd.index];
					res.found_points = pts_mem[cmd.index];
					res.is_old = (age_mem[cmd.index] >= old_age);
				end
			end
			default: ;
		endcase
		res.entry_count = held[COUNT_W-1:0];
	endtask

	task automatic check_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			beat_bad = 1'b1;
			if (shown < 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, fname, want, got);
			shown++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_t want;
		if (!arst_n) begin
			held = 0;
			old_age = OLD_AGE_RESET;
			result_q.delete();
			errors = 0;
			pending = 0;
			shown = 0;
		end else begin
			if (cfg_we) old_age = cfg_wdata;
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					errors++;
					if (shown < 10)
						$display("%0t: result beat with nothing outstanding", $realtime);
					shown++;
				end else begin
					want = result_q.pop_front();
					beat_bad = 1'b0;
					check_field("status", 64'(want.status), 64'(out_data.status));
					check_field("position", 64'(want.position), 64'(out_data.position));
					check_field("found_key", want.found_key, out_data.found_key);
					check_field("found_age", 64'(want.found_age), 64'(out_data.found_age));
					check_field("found_points", 64'(want.found_points),
						64'(out_data.found_points));
					check_field("is_old", 64'(want.is_old), 64'(out_data.is_old));
					check_field("entry_count", 64'(want.entry_count),
						64'(out_data.entry_count));
					if (beat_bad) errors++;
				end
			end
			if (in_valid && in_ready) begin
				predict_result(in_data, want);
				result_q.push_back(want);
			end
			pending = result_q.size();
		end
	end

endmodule

// File: tb/tb_keyed_record_table_core.sv
`timescale 1ns / 1ps

module tb_keyed_record_table_core;
	import krt_pkg::*;

	localparam int LIMIT_CYCLES  = 1000000;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;
	localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
	localparam logic [31:0] PTS_MIN = 32'h8000_0000;
	localparam logic [31:0] PTS_MAX = 32'h7fff_ffff;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_t        in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_t       out_data;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	int         errors;
	int         pending;
	int         cycles = 0;
	int         hold_req = 0;
	int         hold_ack = 0;
	int         hold_left = 0;
	int         ready_pct = 100;
	int         pattern_left = 0;
	logic [KEY_W-1:0] key_pool [16];

	always #2 clk = ~clk;

	keyed_record_table_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	keyed_record_table_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				pattern_left <= $urandom_range(20, 160);
				case ($urandom_range(0, 3))
					0: ready_pct <= 100;
					1: ready_pct <= 75;
					2: ready_pct <= 40;
					default: ready_pct <= 10;
				endcase
			end else begin
				pattern_left <= pattern_left - 1;
			end
			out_ready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	task automatic send_beat(input in_t beat);
		in_data <= beat;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_cmd(input logic [2:0] op, input logic [KEY_W-1:0] key,
			input logic [7:0] age, input logic [31:0] points, input logic [5:0] index);
		in_t beat;
		beat.opcode = op;
		beat.key = key;
		beat.age = age;
		beat.points = points;
		beat.index = index;
		send_beat(beat);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] value);
		drain();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_cmd(input int add_w, output in_t beat);
		int r;
		r = $urandom_range(0, 99);
		if (r < add_w) begin
			beat.opcode = OP_ADD;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 25) beat.opcode = OP_DELETE;
			else if (r < 45) beat.opcode = OP_SET_AGE;
			else if (r < 65) beat.opcode = OP_SET_POINTS;
			else if (r < 95) beat.opcode = OP_READ;
			else beat.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		end
		beat.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 15)] :
			{$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: beat.age = '0;
			1: beat.age = '1;
			default: beat.age = 8'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: beat.points = PTS_MIN;
			1: beat.points = PTS_MAX;
			default: beat.points = 32'($urandom);
		endcase
		beat.index = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 15)) :
			6'($urandom_range(0, 63));
	endtask

	task automatic random_phase(input int items, input int add_w, input bit with_hold);
		in_t beat;
		int burst;
		burst = $urandom_range(1, 24);
		for (int n = 0; n < items; n++) begin
			if (with_hold && n == 20) hold_req <= hold_req + 1;
			random_cmd(add_w, beat);
			send_beat(beat);
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(negedge clk);
				end
			end
		end
	endtask

	initial begin
		key_pool[0] = '0;
		key_pool[1] = KEY_ONES;
		for (int i = 2; i < 16; i++) key_pool[i] = {$urandom, $urandom};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_cmd(OP_READ, '0, '0, '0, 6'd0);
		send_cmd(OP_DELETE, KEY_ONES, '0, '0, '0);
		send_cmd(OP_SET_AGE, '0, 8'd40, '0, '0);
		send_cmd(OP_SET_POINTS, '0, '0, 32'd5, '0);
		send_cmd(OP_SPARE_LO, KEY_ONES, '1, '1, '1);
		send_cmd(OP_SPARE_HI, '0, '0, '0, '0);
		send_cmd(OP_ADD, KEY_ONES, 8'd255, PTS_MIN, '1);
		send_cmd(OP_ADD, '0, 8'd0, PTS_MAX, '0);
		send_cmd(OP_ADD, KEY_ONES, 8'd17, 32'hffff_ffff, '0);
		send_cmd(OP_ADD, key_pool[2], 8'd18, 32'd0, '0);
		for (int i = 0; i < 4; i++) send_cmd(OP_READ, '0, '0, '0, i[5:0]);
		send_cmd(OP_READ, '0, '0, '0, 6'd63);
		send_cmd(OP_READ, '0, '0, '0, 6'd4);
		send_cmd(OP_SET_AGE, KEY_ONES, 8'd18, '0, '0);
		send_cmd(OP_SET_POINTS, '0, '0, PTS_MIN, '0);
		send_cmd(OP_READ, '0, '0, '0, 6'd0);
		send_cmd(OP_READ, '0, '0, '0, 6'd2);
		send_cmd(OP_DELETE, KEY_ONES, '0, '0, '0);
		send_cmd(OP_READ, '0, '0, '0, 6'd0);
		send_cmd(OP_DELETE, key_pool[2], '0, '0, '0);
		send_cmd(OP_READ, '0, '0, '0, 6'd1);
		send_cmd(OP_SPARE_MID, '1, '1, '1, '1);

		write_threshold(8'd0);
		random_phase(120, 80, 1'b1);
		write_threshold(8'hff);
		random_phase(120, 0, 1'b0);
		write_threshold(8'($urandom));
		random_phase(80, 40, 1'b0);
		write_threshold(OLD_AGE_RESET);
		random_phase(80, 55, 1'b0);
		drain();

		if (errors == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/krt_pkg.sv
rtl/core/keyed_record_table_core.sv
rtl/core/krt_checker.sv
tb/keyed_record_table_checker.sv
tb/tb_keyed_record_table_core.sv
